[hw/rtl/slfd_pkg.sv]
// shared types, constants and helper functions of the stereo lagrange fractional delay
// depends on nothing; taken in by scoped names in the controller, datapath, top level and testbench
`timescale 1ns / 1ps
`default_nettype none

package slfd_pkg;

   localparam int RING_DEPTH_DEF = 8192;
   localparam int TAP_COUNT      = 8;
   localparam int SAMPLE_W       = 24;
   localparam int DELAY_W        = 29;
   localparam int WEIGHT_W       = 19;
   localparam int DIV_STEPS      = 1;

   localparam logic [DELAY_W-1:0] MIN_DELAY     = 29'd262144;
   localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 29'd536543232;

   // one datapath operation per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_START,
      OP_PINIT,
      OP_MUL_PLO,
      OP_MUL_PHI,
      OP_PUPD,
      OP_DIVINIT,
      OP_DIVSTEP,
      OP_WSTORE,
      OP_RDTAP,
      OP_MUL_L,
      OP_MUL_R,
      OP_ACC_R,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] k;    // weight being built
      logic [2:0] j;    // factor of that weight
      logic [2:0] tap;  // tap being accumulated
   } dp_cmd_type;

   typedef struct packed {
      logic miss;       // clamped delay differs from the cached one, or none is cached yet
   } dp_stat_type;

   // magnitude of the lagrange denominator, product of (k - j) over j != k
   function automatic logic [12:0] den_mag(input logic [2:0] k);
      logic [12:0] m;
      case (k)
         3'd0, 3'd7: m = 13'd5040;
         3'd1, 3'd6: m = 13'd720;
         3'd2, 3'd5: m = 13'd240;
         default:    m = 13'd144;
      endcase
      return m;
   endfunction

   // reciprocal of the odd part of the denominator, exact for any 29-bit dividend
   function automatic logic [29:0] den_recip(input logic [2:0] k);
      logic [29:0] r;
      case (k)
         3'd0, 3'd7: r = 30'd872628277;  // 315, shift 38
         3'd1, 3'd6: r = 30'd763549742;  // 45, shift 35
         3'd2, 3'd5: r = 30'd572662307;  // 15, shift 33
         default:    r = 30'd954437177;  // 9, shift 33
      endcase
      return r;
   endfunction

   // the denominator is negative for an odd count of negative factors
   function automatic logic den_neg(input logic [2:0] k);
      return ~k[0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/slfd_ctrl.sv]
// sequencing state machine: weight build, tap accumulation and result handover
// depends on slfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module slfd_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   input  slfd_pkg::dp_stat_type   stat,
   output slfd_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_WINIT, S_WMLO, S_WMHI, S_WPUPD, S_DIVINIT, S_DIV,
      S_WSTORE, S_RADDR, S_MULL, S_MULR, S_ACCR, S_OUT
   } state_type;

   state_type  state_ff;
   logic [2:0] k_ff;
   logic [3:0] j_ff;
   logic [2:0] tap_ff;
   logic [4:0] cnt_ff;
   logic       rsp_valid_ff;

   logic       accept;
   logic       fire;
   logic [3:0] nj1;
   logic [3:0] nj;
   logic [2:0] k_in;
   logic [3:0] j_first;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign fire       = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // next factor index, stepping over the weight's own position
   assign nj1     = j_ff + 4'd1;
   assign nj      = (nj1 == {1'b0, k_ff}) ? nj1 + 4'd1 : nj1;
   assign k_in    = k_ff + 3'd1;
   assign j_first = (k_in == 3'd0) ? 4'd1 : 4'd0;

   always_comb begin
      cmd.k   = k_ff;
      cmd.j   = j_ff[2:0];
      cmd.tap = tap_ff;
      case (state_ff)
         S_IDLE:    cmd.op = accept ? slfd_pkg::OP_LATCH : slfd_pkg::OP_NONE;
         S_CHECK:   cmd.op = slfd_pkg::OP_START;
         S_WINIT:   cmd.op = slfd_pkg::OP_PINIT;
         S_WMLO:    cmd.op = slfd_pkg::OP_MUL_PLO;
         S_WMHI:    cmd.op = slfd_pkg::OP_MUL_PHI;
         S_WPUPD:   cmd.op = slfd_pkg::OP_PUPD;
         S_DIVINIT: cmd.op = slfd_pkg::OP_DIVINIT;
         S_DIV:     cmd.op = slfd_pkg::OP_DIVSTEP;
         S_WSTORE:  cmd.op = slfd_pkg::OP_WSTORE;
         S_RADDR:   cmd.op = slfd_pkg::OP_RDTAP;
         S_MULL:    cmd.op = slfd_pkg::OP_MUL_L;
         S_MULR:    cmd.op = slfd_pkg::OP_MUL_R;
         S_ACCR:    cmd.op = slfd_pkg::OP_ACC_R;
         S_OUT:     cmd.op = fire ? slfd_pkg::OP_FINISH : slfd_pkg::OP_NONE;
         default:   cmd.op = slfd_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         j_ff         <= '0;
         tap_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces one taken in the same cycle
         rsp_valid_ff <= fire || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            S_IDLE: begin
               if (accept) state_ff <= S_CHECK;
            end
            S_CHECK: begin
               tap_ff <= '0;
               k_ff   <= '0;
               j_ff   <= 4'd1;
               state_ff <= stat.miss ? S_WINIT : S_RADDR;
            end
            S_WINIT:  state_ff <= S_WMLO;
            S_WMLO:   state_ff <= S_WMHI;
            S_WMHI:   state_ff <= S_WPUPD;
            S_WPUPD: begin
               j_ff     <= nj;
               state_ff <= nj[3] ? S_DIVINIT : S_WMLO;
            end
            S_DIVINIT: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(slfd_pkg::DIV_STEPS - 1)) state_ff <= S_WSTORE;
            end
            S_WSTORE: begin
               k_ff <= k_in;
               j_ff <= j_first;
               state_ff <= (k_ff == 3'(slfd_pkg::TAP_COUNT - 1)) ? S_RADDR : S_WINIT;
            end
            S_RADDR: state_ff <= S_MULL;
            S_MULL:  state_ff <= S_MULR;
            S_MULR:  state_ff <= S_ACCR;
            S_ACCR: begin
               tap_ff   <= tap_ff + 3'd1;
               state_ff <= (tap_ff == 3'(slfd_pkg::TAP_COUNT - 1)) ? S_OUT : S_RADDR;
            end
            S_OUT: begin
               if (fire) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[hw/rtl/slfd_dp.sv]
// datapath: sample ring, weight cache, shared multiplier, reciprocal divide and accumulators
// depends on slfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module slfd_dp #(
   parameter int RING_DEPTH = slfd_pkg::RING_DEPTH_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  slfd_pkg::dp_cmd_type    cmd,
   output slfd_pkg::dp_stat_type   stat,
   input  wire  [23:0]             left_in,
   input  wire  [23:0]             right_in,
   input  wire  [28:0]             delay_amount,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [28:0]             csr_data,
   output logic [23:0]             left_out,
   output logic [23:0]             right_out
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int WW = (AW > 14) ? AW : 14;
   localparam logic [AW:0] DEPTH_V = (AW + 1)'(RING_DEPTH);

   logic [47:0]        ring [RING_DEPTH];
   logic [47:0]        rd_ff;
   logic               rd_ok_ff;
   logic [AW-1:0]      wp_ff;
   logic [AW:0]        fill_ff;

   logic [28:0]        max_delay_ff;
   logic [28:0]        cached_ff;
   logic               cached_ok_ff;
   logic [28:0]        d_ff;
   logic [23:0]        left_ff;
   logic [23:0]        right_ff;

   logic signed [18:0] wt_ff [slfd_pkg::TAP_COUNT];
   logic signed [47:0] p_ff;
   logic signed [43:0] prod_ff;
   logic signed [43:0] part_ff;
   logic [28:0]        rem_ff;
   logic [58:0]        qprod_ff;
   logic               neg_ff;
   logic signed [45:0] accl_ff;
   logic signed [45:0] accr_ff;
   logic [23:0]        outl_ff;
   logic [23:0]        outr_ff;

   logic [28:0]        d_lim;
   logic [28:0]        d_clamp;
   logic signed [24:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [43:0] mul_p;
   logic signed [18:0] factor;
   logic signed [67:0] p_sum;
   logic [47:0]        p_mag;
   logic [48:0]        num;
   logic [25:0]        q_val;
   logic [26:0]        q_neg;
   logic signed [18:0] w_val;
   logic [WW-1:0]      dist_w;
   logic [AW-1:0]      tap_dist;
   logic [AW:0]        dist_eff;
   logic [AW-1:0]      rd_addr;
   logic [23:0]        smp_l;
   logic [23:0]        smp_r;

   function automatic logic [23:0] sat_out(input logic signed [45:0] acc);
      logic signed [46:0] r;
      logic signed [30:0] v;
      r = {acc[45], acc} + 47'sd32768;
      v = r[46:16];
      if (v > 31'sd8388607)       return 24'h7FFFFF;
      else if (v < -31'sd8388608) return 24'h800000;
      else                        return v[23:0];
   endfunction

   assign csr_ready = 1'b1;
   assign stat.miss = !cached_ok_ff || (d_ff != cached_ff);
   assign left_out  = outl_ff;
   assign right_out = outr_ff;

   // delay clamp: the lower bound wins when the register sits below it
   assign d_lim   = (delay_amount > max_delay_ff) ? max_delay_ff : delay_amount;
   assign d_clamp = (d_lim < slfd_pkg::MIN_DELAY) ? slfd_pkg::MIN_DELAY : d_lim;

   // factor (f - j) in q.16, j = cmd.j - 3
   assign factor = $signed({3'(3'd3 - cmd.j), d_ff[15:0]});

   assign smp_l = rd_ok_ff ? rd_ff[23:0]  : 24'd0;
   assign smp_r = rd_ok_ff ? rd_ff[47:24] : 24'd0;

   always_comb begin
      case (cmd.op)
         slfd_pkg::OP_MUL_PLO: begin
            mul_a = $signed({1'b0, p_ff[23:0]});
            mul_b = factor;
         end
         slfd_pkg::OP_MUL_PHI: begin
            mul_a = $signed({p_ff[47], p_ff[47:24]});
            mul_b = factor;
         end
         slfd_pkg::OP_MUL_L: begin
            mul_a = $signed({smp_l[23], smp_l});
            mul_b = wt_ff[cmd.tap];
         end
         slfd_pkg::OP_MUL_R: begin
            mul_a = $signed({smp_r[23], smp_r});
            mul_b = wt_ff[cmd.tap];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // recombine the two partial products and round to q.32
   assign p_sum = {{24{prod_ff[43]}}, prod_ff} * 68'sd16777216
                + {{24{part_ff[43]}}, part_ff} + 68'sd32768;

   // rounded quotient: the power of two of the denominator and the 2^16 scale come off
   // as a shift, the odd part goes by reciprocal multiplication
   assign p_mag = p_ff[47] ? 48'(-p_ff) : p_ff;
   assign num   = {1'b0, p_mag} + {21'd0, slfd_pkg::den_mag(cmd.k), 15'd0};

   always_comb begin
      case (cmd.k)
         3'd0, 3'd7: q_val = 26'(qprod_ff >> 38);
         3'd1, 3'd6: q_val = 26'(qprod_ff >> 35);
         default:    q_val = 26'(qprod_ff >> 33);
      endcase
   end

   assign q_neg = 27'(-$signed({1'b0, q_val}));

   always_comb begin
      if (!neg_ff) begin
         w_val = (q_val > 26'd262143) ? 19'sd262143 : $signed(q_val[18:0]);
      end else begin
         w_val = (q_val > 26'd262144) ? $signed(19'h40000) : $signed(q_neg[18:0]);
      end
   end

   // tap distance whole - 3 + tap, taken modulo the ring depth
   assign dist_w   = WW'(d_ff[28:16]) + WW'(cmd.tap) - WW'(3);
   assign tap_dist = dist_w[AW-1:0];
   assign dist_eff = (tap_dist == '0) ? DEPTH_V : {1'b0, tap_dist};
   assign rd_addr  = wp_ff - tap_dist;

   // ring storage
   always_ff @(posedge clock) begin
      if (cmd.op == slfd_pkg::OP_FINISH) ring[wp_ff] <= {right_ff, left_ff};
      if (cmd.op == slfd_pkg::OP_RDTAP) rd_ff <= ring[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_delay_ff <= slfd_pkg::MAX_DELAY_RST;
         cached_ff    <= '1;
         cached_ok_ff <= 1'b0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) max_delay_ff <= csr_data;
         if (cmd.op == slfd_pkg::OP_START && stat.miss) begin
            cached_ff    <= d_ff;
            cached_ok_ff <= 1'b1;
         end
         // entries beyond the fill count were never written and read as zero
         if (cmd.op == slfd_pkg::OP_RDTAP) rd_ok_ff <= (dist_eff <= fill_ff);
         if (cmd.op == slfd_pkg::OP_FINISH) begin
            wp_ff <= wp_ff + 1'b1;
            if (fill_ff != DEPTH_V) fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         slfd_pkg::OP_LATCH: begin
            left_ff  <= left_in;
            right_ff <= right_in;
            d_ff     <= d_clamp;
         end
         slfd_pkg::OP_START: begin
            accl_ff <= '0;
            accr_ff <= '0;
         end
         slfd_pkg::OP_PINIT:   p_ff <= 48'sd4294967296;
         slfd_pkg::OP_MUL_PLO: prod_ff <= mul_p;
         slfd_pkg::OP_MUL_PHI: begin
            part_ff <= prod_ff;
            prod_ff <= mul_p;
         end
         slfd_pkg::OP_PUPD:    p_ff <= p_sum[63:16];
         slfd_pkg::OP_DIVINIT: begin
            rem_ff <= num[48:20];
            neg_ff <= p_ff[47] ^ slfd_pkg::den_neg(cmd.k);
         end
         slfd_pkg::OP_DIVSTEP: begin
            qprod_ff <= 59'(rem_ff) * 59'(slfd_pkg::den_recip(cmd.k));
         end
         slfd_pkg::OP_WSTORE:  wt_ff[cmd.k] <= w_val;
         slfd_pkg::OP_MUL_L:   prod_ff <= mul_p;
         slfd_pkg::OP_MUL_R: begin
            accl_ff <= accl_ff + 46'(prod_ff);
            prod_ff <= mul_p;
         end
         slfd_pkg::OP_ACC_R:   accr_ff <= accr_ff + 46'(prod_ff);
         slfd_pkg::OP_FINISH: begin
            outl_ff <= sat_out(accl_ff);
            outr_ff <= sat_out(accr_ff);
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/stereo_lagrange_fractional_delay_top.sv]
// top level of the stereo 8-point lagrange fractional delay line
// depends on slfd_pkg, slfd_ctrl and slfd_dp
//
//   channel  dir  handshake               payload
//   req      in   req_tvalid/req_tready   left_in, right_in, delay_amount
//   rsp      out  rsp_tvalid/rsp_tready   left_out, right_out
//   csr      in   csr_valid/csr_ready     max_delay
//
// while the clamped delay matches the cached weights, a frame runs from acceptance to result
// through a check state, 8 taps through the shared multiplier (read, left product, right
// product, accumulate) and the output state; the block then goes back to idle for the next frame
// when the delay changes, 8 weight builds come first (7 factor products through
// the shared multiplier and a reciprocal divide each)
// reset is synchronous; the ring needs no clearing pass, unwritten entries read as zero
// a result waits in the output register, the next frame is taken meanwhile
// RING_DEPTH must be a power of two
`timescale 1ns / 1ps
`default_nettype none

module stereo_lagrange_fractional_delay_top #(
   parameter int RING_DEPTH = slfd_pkg::RING_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [79:0] req_tdata,   // left_in [23:0], right_in [47:24], delay_amount [76:48]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // left_out [23:0], right_out [47:24]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [28:0] csr_data     // max_delay
);

   slfd_pkg::dp_cmd_type  cmd;
   slfd_pkg::dp_stat_type stat;
   logic [23:0]           left_out;
   logic [23:0]           right_out;

   // sequencer
   slfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // ring, weights and arithmetic
   slfd_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .left_in      (req_tdata[23:0]),
      .right_in     (req_tdata[47:24]),
      .delay_amount (req_tdata[76:48]),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .left_out     (left_out),
      .right_out    (right_out)
   );

   assign rsp_tdata = {right_out, left_out};

endmodule

`default_nettype wire

[hw/rtl/slfd_chk.sv]
// port-level checker for the stereo lagrange fractional delay top, with its bind
// depends on stereo_lagrange_fractional_delay_top
`timescale 1ns / 1ps
`default_nettype none

module slfd_chk (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [47:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction dropped or changed while stalled");

   // no result straight after reset
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // one frame at a time: busy after taking a frame
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while a frame is in work");

   // a result never appears in the cycle after the frame that causes it is taken
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("rsp transaction appeared too early");

endmodule

bind stereo_lagrange_fractional_delay_top slfd_chk u_slfd_chk (.*);

`default_nettype wire

[tb/sv/tb_stereo_lagrange_fractional_delay_top.sv]
// self-checking testbench of the stereo 8-point lagrange fractional delay top level
// depends on slfd_pkg and stereo_lagrange_fractional_delay_top
`timescale 1ns / 1ps

module tb_stereo_lagrange_fractional_delay_top;

   localparam int RING = slfd_pkg::RING_DEPTH_DEF;
   localparam int TAPS = slfd_pkg::TAP_COUNT;
   localparam int SW   = slfd_pkg::SAMPLE_W;
   localparam int DW   = slfd_pkg::DELAY_W;
   localparam int WW   = slfd_pkg::WEIGHT_W;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int RANDOM_FRAMES = 1300;
   localparam int SETTLE_CYCLES = 600;

   localparam int W_MAX = 262143;
   localparam int W_MIN = -262144;
   localparam longint O_MAX = 8388607;
   localparam longint O_MIN = -8388608;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [79:0] req_tdata = '0;   // left_in [23:0], right_in [47:24], delay_amount [76:48]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // left_out [23:0], right_out [47:24]
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [28:0] csr_data = '0;    // max_delay

   typedef struct packed {
      logic signed [SW-1:0] left_s;
      logic signed [SW-1:0] right_s;
   } stereo_type;

   typedef struct {
      logic signed [SW-1:0] left_s;
      logic signed [SW-1:0] right_s;
      logic [DW-1:0]        dly;
      logic                 known;   // row carries a typed-in expectation
      stereo_type           typed;
   } frame_row_type;

   // mirror of the block state
   stereo_type           ring_mem [RING];
   logic [12:0]          wr_slot;
   logic [DW-1:0]        cached_dly;
   logic                 cache_ok;
   logic signed [WW-1:0] weight_tab [TAPS];
   logic [DW-1:0]        max_dly;

   stereo_type   pending_out [$];
   frame_row_type frame_q [$];
   int           fail_count = 0;
   int           cycle_count = 0;
   bit           long_hold = 1'b0;
   bit           stim_done = 1'b0;

   stereo_lagrange_fractional_delay_top #(.RING_DEPTH(RING)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // floor division by 2^16 for either sign
   function automatic longint floor16(input longint v);
      return v >>> 16;
   endfunction

   // eight lagrange weights for a Q0.16 fraction
   task automatic build_weights(input logic [15:0] frac);
      longint p, den, mag, dv, q, w;
      bit neg;
      for (int k = -3; k <= 4; k++) begin
         p = longint'(1) << 32;
         den = 1;
         for (int j = -3; j <= 4; j++) begin
            if (j != k) begin
               p = floor16(p * (longint'(frac) - longint'(j) * 65536) + 32768);
               den = den * (k - j);
            end
         end
         neg = (p < 0) != (den < 0);
         mag = p < 0 ? -p : p;
         dv = (den < 0 ? -den : den) * 65536;
         q = (mag + dv / 2) / dv;
         w = neg ? -q : q;
         if (w > W_MAX) w = W_MAX;
         if (w < W_MIN) w = W_MIN;
         weight_tab[k+3] = w[WW-1:0];
      end
   endtask

   function automatic logic signed [SW-1:0] round_sat(input longint acc);
      longint v;
      v = floor16(acc + 32768);
      if (v > O_MAX) v = O_MAX;
      if (v < O_MIN) v = O_MIN;
      return v[SW-1:0];
   endfunction

   // interpolated output for one frame, then the frame goes into the ring
   task automatic delay_line_step(input frame_row_type fr, output stereo_type res);
      logic [DW-1:0] d;
      logic [31:0] whole, tap_dist, idx;
      longint acc_l, acc_r;
      d = fr.dly;
      if (d > max_dly) d = max_dly;
      if (d < slfd_pkg::MIN_DELAY) d = slfd_pkg::MIN_DELAY;
      if (!cache_ok || d != cached_dly) begin
         cached_dly = d;
         cache_ok = 1'b1;
         build_weights(d[15:0]);
      end
      whole = d >> 16;
      acc_l = 0;
      acc_r = 0;
      for (int i = 0; i < TAPS; i++) begin
         tap_dist = (whole - 3 + i) % RING;
         idx = (wr_slot + RING - tap_dist) % RING;
         acc_l += longint'(ring_mem[idx].left_s) * longint'(weight_tab[i]);
         acc_r += longint'(ring_mem[idx].right_s) * longint'(weight_tab[i]);
      end
      res.left_s = round_sat(acc_l);
      res.right_s = round_sat(acc_r);
      ring_mem[wr_slot].left_s = fr.left_s;
      ring_mem[wr_slot].right_s = fr.right_s;
      wr_slot = wr_slot + 1;
   endtask

   // run timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // sender: bursts of random length with gaps, fed from the frame queue
   always @(posedge clock) begin
      frame_row_type fr;
      stereo_type r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            fr = frame_q.pop_front();
            delay_line_step(fr, r);
            // typed rows are checked against the hand value, the rest against the predictor
            pending_out.push_back(fr.known ? fr.typed : r);
         end
         if ((!req_tvalid || req_tready) ) begin
            // offer the next frame with the chance of a gap
            if (frame_q.size() > (req_tvalid && req_tready ? 0 : 0) && $urandom_range(0, 3) != 0)
            begin
               req_tvalid <= 1'b1;
               req_tdata <= {3'b0, frame_q[0].dly, frame_q[0].right_s, frame_q[0].left_s};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: own stall pattern, plus one long hold-off
   always @(posedge clock) begin
      stereo_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.left_s = rsp_tdata[23:0];
            got.right_s = rsp_tdata[47:24];
            if (pending_out.size() == 0) begin
               $display("%0t: unexpected transaction %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_out.pop_front();
               if (got.left_s !== want.left_s || got.right_s !== want.right_s) begin
                  $display("%0t: mismatch expected L %0d R %0d actual L %0d R %0d", $time,
                     want.left_s, want.right_s, got.left_s, got.right_s);
                  fail_count++;
               end
            end
         end
         rsp_tready <= long_hold ? 1'b0 : (cycle_count[7:5] == 3'd5 ? 1'b1 : $urandom_range(0, 2) != 0);
      end
   end

   // frames queued by the stimulus are consumed above, so the ring state ordering holds
   task automatic push_frame(input int l, input int r, input logic [DW-1:0] d,
                             input bit known = 0, input int el = 0, input int er = 0);
      frame_row_type fr;
      fr.left_s = l[SW-1:0];
      fr.right_s = r[SW-1:0];
      fr.dly = d;
      fr.known = known;
      fr.typed.left_s = el[SW-1:0];
      fr.typed.right_s = er[SW-1:0];
      frame_q.push_back(fr);
   endtask

   task automatic wait_idle();
      while (frame_q.size() != 0 || req_tvalid || pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_delay(input logic [DW-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      max_dly = v;
   endtask

   task automatic random_frames(input int n, input int hold_at);
      logic [DW-1:0] d;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) d = DW'($urandom_range(4, 40)) << 16 | DW'($urandom_range(0, 65535));
         else if (sel < 7) d = DW'($urandom_range(4, 12)) << 16;   // repeated delays keep the cache
         else if (sel < 9) d = DW'($urandom_range(0, 32'h1FFFFFFF));
         else d = DW'($urandom_range(8180, 8191)) << 16 | DW'($urandom_range(0, 65535));
         push_frame($urandom_range(0, 32'hFFFFFF), $urandom_range(0, 32'hFFFFFF), d);
         if (i == hold_at) begin
            // hold the receiver off while frames keep coming
            long_hold = 1'b1;
            repeat (3000) @(posedge clock);
            long_hold = 1'b0;
         end
         while (frame_q.size() > 4) @(posedge clock);
      end
   endtask

   typedef struct {
      int l, r;
      logic [DW-1:0] d;
      bit known;
      int el, er;
   } table_row_type;

   table_row_type directed_tab [] = '{
      // empty ring reads zero
      '{ 8388607, -8388608, 29'h0,        1, 0, 0},
      '{-8388608,  8388607, 29'h1FFFFFFF, 1, 0, 0},
      '{ 1,       -1,       29'h40000,    1, 0, 0},
      '{ 4000000, -4000000, 29'h48000,    0, 0, 0},
      '{ 8388607,  8388607, 29'h50001,    0, 0, 0},
      '{-8388608, -8388608, 29'h4FFFF,    0, 0, 0},
      '{ 123456,  -654321,  29'h40000,    0, 0, 0},
      // integer delay 4 returns the frame four steps back
      '{ 0,        0,       29'h40000,    1, 4000000, -4000000},
      '{ 8388607, -8388608, 29'h5C000,    0, 0, 0},
      '{-1,        1,       29'h3FFFF,    0, 0, 0},
      '{ 77,      -77,      29'h1FFC0000, 0, 0, 0},
      '{ 8388607,  8388607, 29'h60000,    0, 0, 0},
      '{ 8388607,  8388607, 29'h6C000,    0, 0, 0},
      '{ 8388607,  8388607, 29'h6C000,    0, 0, 0},
      '{-8388608, -8388608, 29'h48000,    0, 0, 0}
   };

   initial begin
      max_dly = slfd_pkg::MAX_DELAY_RST;
      wr_slot = '0;
      cached_dly = '1;
      cache_ok = 1'b0;
      for (int i = 0; i < RING; i++) ring_mem[i] = '0;
      for (int i = 0; i < TAPS; i++) weight_tab[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_tab[i])
         push_frame(directed_tab[i].l, directed_tab[i].r, directed_tab[i].d,
                    directed_tab[i].known, directed_tab[i].el, directed_tab[i].er);
      wait_idle();

      // clamp crossing, lowest and highest legal settings, an all-ones setting, then a mid value
      write_max_delay(29'h10000);
      push_frame(5, 6, 29'h100000);
      push_frame(-5, -6, 29'h1FFFFFFF);
      wait_idle();
      write_max_delay(slfd_pkg::MIN_DELAY);
      random_frames(100, -1);
      wait_idle();
      write_max_delay(29'd536543232);
      random_frames(500, 200);
      wait_idle();
      write_max_delay(29'h1FFFFFFF);
      random_frames(200, -1);
      wait_idle();
      write_max_delay(29'h00123456);
      random_frames(RANDOM_FRAMES - 800, -1);
      wait_idle();

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/slfd_pkg.sv
hw/rtl/slfd_ctrl.sv
hw/rtl/slfd_dp.sv
hw/rtl/stereo_lagrange_fractional_delay_top.sv
hw/rtl/slfd_chk.sv
tb/sv/tb_stereo_lagrange_fractional_delay_top.sv
